@@ rtl/qed_pkg.sv @@
// ----------------------------------------------------------------------------
// qed_pkg: shared types for the quadrature encoder debounce decoder
// Holds the packed input item, result item and decoder state layouts.
// ----------------------------------------------------------------------------
package qed_pkg;

    localparam int unsigned CountWidth = 8;
    localparam int unsigned InBits     = 6;
    localparam int unsigned OutBits    = 3;
    localparam int unsigned DataWidth  = 8;

    localparam logic [CountWidth-1:0] DebounceTicksReset = 8'd3;

    // input transaction, pin_a in the lowest bit
    typedef struct packed {
        logic clear_moved;
        logic button_tick;
        logic encoder_tick;
        logic pin_switch;
        logic pin_b;
        logic pin_a;
    } item_t;

    // result transaction, button_pressed in the lowest bit
    typedef struct packed {
        logic direction;
        logic moved;
        logic button_pressed;
    } result_t;

    // decoder state carried from one transaction to the next
    typedef struct packed {
        logic                  prev_level_a;
        logic                  prev_level_b;
        logic                  armed_a;
        logic                  armed_b;
        logic [CountWidth-1:0] wait_count_a;
        logic [CountWidth-1:0] wait_count_b;
        logic                  active_a;
        logic                  active_b;
        logic                  moved_flag;
        logic                  last_direction;
        logic                  pressed_flag;
    } state_t;

    localparam state_t StateReset = '{
        prev_level_a:   1'b1,
        prev_level_b:   1'b1,
        armed_a:        1'b0,
        armed_b:        1'b0,
        wait_count_a:   '0,
        wait_count_b:   '0,
        active_a:       1'b0,
        active_b:       1'b0,
        moved_flag:     1'b0,
        last_direction: 1'b0,
        pressed_flag:   1'b0
    };

endpackage

@@ rtl/qed_step.sv @@
// ----------------------------------------------------------------------------
// qed_step: one decoder step
// Edge arming, debounce checks for channel A then B, button latch, result
// and read-and-clear of the moved flag, all as combinational logic.
// ----------------------------------------------------------------------------
module qed_step
    import qed_pkg::*;
(
    input  state_t                st,
    input  item_t                 item,
    input  logic [CountWidth-1:0] debounce_ticks,
    output state_t                st_next,
    output result_t               result
);

    logic arm_a;
    logic arm_b;

    // falling edge arms a channel
    assign arm_a = st.armed_a | (st.prev_level_a & ~item.pin_a);
    assign arm_b = st.armed_b | (st.prev_level_b & ~item.pin_b);

    always_comb begin
        st_next              = st;
        st_next.prev_level_a = item.pin_a;
        st_next.prev_level_b = item.pin_b;
        st_next.armed_a      = arm_a;
        st_next.armed_b      = arm_b;

        if (item.encoder_tick) begin
            // channel a: completing a step means right
            if (arm_a) begin
                if (st.wait_count_a >= debounce_ticks) begin
                    if (!item.pin_a) begin
                        if (st.active_b) begin
                            st_next.moved_flag     = 1'b1;
                            st_next.last_direction = 1'b1;
                            st_next.active_a       = 1'b0;
                            st_next.active_b       = 1'b0;
                        end else begin
                            st_next.active_a = 1'b1;
                        end
                    end else begin
                        st_next.active_a = 1'b0;
                    end
                    // counter restarts at one after a check
                    st_next.armed_a      = 1'b0;
                    st_next.wait_count_a = CountWidth'(1);
                end else begin
                    st_next.wait_count_a = CountWidth'(st.wait_count_a + 1'b1);
                end
            end

            // channel b sees channel a's update: completing means left
            if (arm_b) begin
                if (st.wait_count_b >= debounce_ticks) begin
                    if (!item.pin_b) begin
                        if (st_next.active_a) begin
                            st_next.moved_flag     = 1'b1;
                            st_next.last_direction = 1'b0;
                            st_next.active_a       = 1'b0;
                            st_next.active_b       = 1'b0;
                        end else begin
                            st_next.active_b = 1'b1;
                        end
                    end else begin
                        st_next.active_b = 1'b0;
                    end
                    st_next.armed_b      = 1'b0;
                    st_next.wait_count_b = CountWidth'(1);
                end else begin
                    st_next.wait_count_b = CountWidth'(st.wait_count_b + 1'b1);
                end
            end
        end

        // button latch, pin is active low
        if (item.button_tick) begin
            st_next.pressed_flag = ~item.pin_switch;
        end

        result.button_pressed = st_next.pressed_flag;
        result.moved          = st_next.moved_flag;
        result.direction      = st_next.last_direction;

        // moved flag clears only after it has been reported
        if (item.clear_moved) begin
            st_next.moved_flag = 1'b0;
        end
    end

endmodule

@@ rtl/quadrature_encoder_debounce_decoder_core.sv @@
// ----------------------------------------------------------------------------
// quadrature_encoder_debounce_decoder_core: encoder and button debounce top
// Input register, one decoder step, result register, stream handshakes.
// ----------------------------------------------------------------------------
// The input transaction is captured in the input register, and its result is
// registered in the result register, which drives m_tvalid.
// Throughput: one transaction per cycle unless m_tready stalls; the state
// update is one pass of the step logic between input and result registers.
// Reset: synchronous active-low aresetn empties both registers, restores
// the decoder state and sets debounce_ticks to 3.
module quadrature_encoder_debounce_decoder_core
    import qed_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CountWidth-1:0] cfg_wr_data,  // debounce_ticks
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] pin_a, [1] pin_b, [2] pin_switch, [3] encoder_tick,
    // [4] button_tick, [5] clear_moved, [7:6] unused
    input  logic [DataWidth-1:0]  s_tdata,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] button_pressed, [1] moved, [2] direction, [7:3] zero
    output logic [DataWidth-1:0]  m_tdata
);

    logic                  in_valid_reg;
    item_t                 in_item_reg;
    logic                  out_valid_reg;
    result_t               out_result_reg;
    state_t                state_reg;
    state_t                state_next;
    result_t               result_next;
    logic [CountWidth-1:0] debounce_ticks_reg;
    logic                  advance;

    // the step runs when the input register can move into the result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg <= DebounceTicksReset;
        end else if (cfg_wr_en) begin
            debounce_ticks_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= item_t'(s_tdata[InBits-1:0]);
        end
    end

    qed_step u_step (
        .st             (state_reg),
        .item           (in_item_reg),
        .debounce_ticks (debounce_ticks_reg),
        .st_next        (state_next),
        .result         (result_next)
    );

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StateReset;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(DataWidth-OutBits){1'b0}}, out_result_reg};

`ifndef ASSERT_OFF
    // a completed step always clears both active flags
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg.active_a && state_reg.active_b))
        else $error("both channels active at once");

    // state only moves when a transaction goes through the step
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("decoder state changed without a step");

    // a step always leaves a result waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("step produced no result");

    // an empty input register always takes a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");
`endif

endmodule
